FILE: design/pprrs_pkg.sv
// Package for the preemptive priority round-robin scheduler.
// Holds the task word layout, store sizing and reset constants.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pprrs_pkg;

    // Storage sizing. The total number of tasks held in the block never exceeds MAX_TASKS.
    localparam int MAX_TASKS = 16;
    localparam int IDX_W     = (MAX_TASKS > 2) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int NODES     = 1 << IDX_W;

    // Field widths.
    localparam int ID_W     = 8;
    localparam int PRIO_W   = 8;
    localparam int REMAIN_W = 16;
    localparam int SLICE_W  = 8;

    // Reset value of the time slice register and of the slice counter.
    localparam logic [SLICE_W-1:0] SLICE_RESET = SLICE_W'(4);

    // Task word: remaining ticks in the top half, then priority, then id.
    typedef struct packed {
        logic [REMAIN_W-1:0] remain;
        logic [PRIO_W-1:0]   prio;
        logic [ID_W-1:0]     id;
    } t_task;

    typedef t_task [MAX_TASKS-1:0] t_task_arr;

    // Result of the most-urgent search over the priority store.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        t_task            entry;
    } t_best;

endpackage

`default_nettype wire

FILE: design/pprrs_best_sel.sv
// Most-urgent task search over the priority store.
// A comparator tree picks the lowest {priority, id}; ties go to the lower slot.
// Depends on pprrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pprrs_best_sel (
    input  wire pprrs_pkg::t_task_arr                  i_entries,
    input  wire logic [pprrs_pkg::MAX_TASKS-1:0]       i_valid_mask,
    output pprrs_pkg::t_best                           o_best
);

    localparam int N = pprrs_pkg::NODES;

    // Tree nodes in heap order: node 1 is the root, leaves start at N.
    logic                          nd_valid [1:2*N-1];
    logic [pprrs_pkg::IDX_W-1:0]   nd_idx   [1:2*N-1];
    pprrs_pkg::t_task              nd_task  [1:2*N-1];

    // Leaves: one per store slot, padding slots never win.
    for (genvar i = 0; i < N; i++) begin : g_leaf
        if (i < pprrs_pkg::MAX_TASKS) begin : g_real
            assign nd_valid[N+i] = i_valid_mask[i];
            assign nd_task[N+i]  = i_entries[i];
        end else begin : g_pad
            assign nd_valid[N+i] = 1'b0;
            assign nd_task[N+i]  = '0;
        end
        assign nd_idx[N+i] = pprrs_pkg::IDX_W'(i);
    end

    // Internal nodes: the right child wins when the left is empty or with a strictly smaller key.
    for (genvar n = 1; n < N; n++) begin : g_node
        logic pick_r;
        assign pick_r = nd_valid[2*n+1] &&
                        (!nd_valid[2*n] ||
                         ({nd_task[2*n+1].prio, nd_task[2*n+1].id} <
                          {nd_task[2*n].prio, nd_task[2*n].id}));
        assign nd_valid[n] = nd_valid[2*n] | nd_valid[2*n+1];
        assign nd_idx[n]   = pick_r ? nd_idx[2*n+1]  : nd_idx[2*n];
        assign nd_task[n]  = pick_r ? nd_task[2*n+1] : nd_task[2*n];
    end

    assign o_best.found = nd_valid[1];
    assign o_best.idx   = nd_idx[1];
    assign o_best.entry = nd_task[1];

endmodule

`default_nettype wire

FILE: design/preemptive_priority_rr_scheduler.sv
// Top level of the preemptive priority scheduler with round-robin fallback.
// Depends on pprrs_pkg and pprrs_best_sel.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one transaction per item:
//   i_func = 0 is a task arrival (i_task_id, i_priority_req, i_burst),
//   i_func = 1 is one scheduler tick. Every item gives exactly one result on
//   the output channel (o_valid / i_stall).
//   An accepted item sits in the input register, where the whole
//   scheduling decision and the service of one tick are evaluated and
//   stored in the result register, which presents the result. One item
//   is taken every cycle while the output is not stalled. The cycle
//   time is set by the 16-entry comparator tree feeding the store shift.
//   While the output is stalled the result register holds, one more item
//   may still be taken into the input register, and then o_stall rises.
//   time_slice is written through i_cfg_we / i_cfg_wdata while no
//   transaction is in flight.
//   Synchronous reset (i_rst_n low) empties both task stores, idles the
//   processor, drops any pending transaction and sets time_slice to 4.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_rr_scheduler (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [pprrs_pkg::SLICE_W-1:0]    i_cfg_wdata,
    // Input channel
    input  wire logic                             i_valid,
    output      logic                             o_stall,
    input  wire logic                             i_func,
    input  wire logic [pprrs_pkg::ID_W-1:0]       i_task_id,
    input  wire logic [pprrs_pkg::PRIO_W-1:0]     i_priority_req,
    input  wire logic [pprrs_pkg::REMAIN_W-1:0]   i_burst,
    // Output channel
    output      logic                             o_valid,
    input  wire logic                             i_stall,
    output      logic                             o_busy_res,
    output      logic [pprrs_pkg::ID_W-1:0]       o_running_id,
    output      logic                             o_done_res,
    output      logic                             o_sliced_out,
    output      logic                             o_dropped
);

    localparam int MAXT  = pprrs_pkg::MAX_TASKS;
    localparam int IDX_W = pprrs_pkg::IDX_W;
    localparam int CNT_W = pprrs_pkg::CNT_W;

    // Wrapping increment of a FIFO pointer.
    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (p == IDX_W'(MAXT - 1)) r = '0;
        else                       r = p + IDX_W'(1);
        return r;
    endfunction

    // ---------------- Registers ----------------
    logic                               r_in_valid;
    logic                               r_in_func;
    pprrs_pkg::t_task                   r_in_task;

    logic                               r_out_valid;
    logic                               r_busy_res;
    logic [pprrs_pkg::ID_W-1:0]         r_running_id;
    logic                               r_done_res;
    logic                               r_sliced_out;
    logic                               r_dropped;

    logic [pprrs_pkg::SLICE_W-1:0]      r_time_slice;
    pprrs_pkg::t_task_arr               r_prio;
    logic [CNT_W-1:0]                   r_prio_cnt;
    pprrs_pkg::t_task                   r_fifo [MAXT];
    logic [IDX_W-1:0]                   r_head;
    logic [IDX_W-1:0]                   r_tail;
    logic [CNT_W-1:0]                   r_rr_cnt;
    pprrs_pkg::t_task                   r_cur;
    logic                               r_busy;
    logic                               r_from_prio;
    logic                               r_from_fifo;
    logic [pprrs_pkg::SLICE_W-1:0]      r_slice_left;

    // ---------------- Next-state values ----------------
    logic [CNT_W-1:0]                   n_prio_cnt;
    logic [IDX_W-1:0]                   n_head;
    logic [IDX_W-1:0]                   n_tail;
    logic [CNT_W-1:0]                   n_rr_cnt;
    pprrs_pkg::t_task                   n_cur;
    logic                               n_busy;
    logic                               n_from_prio;
    logic                               n_from_fifo;
    logic [pprrs_pkg::SLICE_W-1:0]      n_slice_left;
    logic                               n_busy_res;
    logic [pprrs_pkg::ID_W-1:0]         n_running_id;
    logic                               n_done_res;
    logic                               n_sliced_out;
    logic                               n_dropped;

    // ---------------- Decision signals ----------------
    logic                               out_blocked;
    logic                               proc;
    logic                               is_tick;
    logic                               arr_ok;
    logic                               take_prio;
    logic                               pop_fifo;
    logic                               preempt;
    logic                               push1;
    logic                               push2;
    logic [IDX_W-1:0]                   tail1;
    logic [CNT_W-1:0]                   rr_cnt1;
    pprrs_pkg::t_task                   run_task;
    pprrs_pkg::t_task                   served;
    logic                               run_busy;
    logic [pprrs_pkg::SLICE_W-1:0]      run_slice;
    logic [pprrs_pkg::SLICE_W-1:0]      slice_dec;
    logic [CNT_W:0]                     total;
    logic [MAXT-1:0]                    valid_mask;
    pprrs_pkg::t_best                   best;

    // Handshake: the stage moves when the result register can take a new result.
    assign out_blocked = r_out_valid && i_stall;
    assign proc        = r_in_valid && !out_blocked;
    assign o_stall     = r_in_valid && out_blocked;

    // Occupied slots of the priority store.
    for (genvar i = 0; i < MAXT; i++) begin : g_mask
        assign valid_mask[i] = (CNT_W'(i) < r_prio_cnt);
    end

    pprrs_best_sel u_best_sel (
        .i_entries    (r_prio),
        .i_valid_mask (valid_mask),
        .o_best       (best)
    );

    // Scheduling decision and one tick of service.
    always_comb begin
        is_tick   = r_in_func;
        total     = (CNT_W+1)'(r_prio_cnt) + (CNT_W+1)'(r_rr_cnt) + (CNT_W+1)'(r_busy);
        arr_ok    = !is_tick && (total < (CNT_W+1)'(MAXT));
        n_dropped = !is_tick && !arr_ok;

        // Dispatch or preemption.
        preempt   = is_tick && r_busy && best.found &&
                    (r_from_prio ? (best.entry.prio < r_cur.prio) : r_from_fifo);
        take_prio = (is_tick && !r_busy && best.found) || preempt;
        pop_fifo  = is_tick && !r_busy && !best.found && (r_rr_cnt != '0);
        push1     = preempt && (r_rr_cnt < CNT_W'(MAXT));

        n_head  = pop_fifo ? ptr_inc(r_head) : r_head;
        tail1   = push1 ? ptr_inc(r_tail) : r_tail;
        rr_cnt1 = r_rr_cnt;
        if (pop_fifo) rr_cnt1 = r_rr_cnt - CNT_W'(1);
        if (push1)    rr_cnt1 = r_rr_cnt + CNT_W'(1);

        if (take_prio)     run_task = best.entry;
        else if (pop_fifo) run_task = r_fifo[r_head];
        else               run_task = r_cur;
        run_busy  = r_busy || take_prio || pop_fifo;
        run_slice = (take_prio || pop_fifo) ? r_time_slice : r_slice_left;

        n_from_prio = take_prio ? 1'b1 : (pop_fifo ? 1'b0 : r_from_prio);
        n_from_fifo = take_prio ? 1'b0 : (pop_fifo ? 1'b1 : r_from_fifo);

        // Serve the running task for one tick.
        slice_dec     = run_slice - pprrs_pkg::SLICE_W'(1);
        served        = run_task;
        served.remain = run_task.remain - pprrs_pkg::REMAIN_W'(1);
        n_busy_res    = 1'b0;
        n_running_id  = '0;
        n_done_res    = 1'b0;
        n_sliced_out  = 1'b0;
        push2         = 1'b0;
        n_cur         = run_task;
        n_busy        = run_busy && is_tick;
        n_slice_left  = run_slice;
        n_rr_cnt      = rr_cnt1;
        n_tail        = tail1;
        if (!is_tick) begin
            n_cur        = r_cur;
            n_busy       = r_busy;
            n_from_prio  = r_from_prio;
            n_from_fifo  = r_from_fifo;
            n_slice_left = r_slice_left;
        end else if (run_busy) begin
            n_busy_res   = 1'b1;
            n_running_id = run_task.id;
            if (run_task.remain <= pprrs_pkg::REMAIN_W'(1)) begin
                n_done_res   = 1'b1;
                n_busy       = 1'b0;
                n_from_prio  = 1'b0;
                n_from_fifo  = 1'b0;
                n_cur        = '0;
                n_slice_left = r_time_slice;
            end else if (slice_dec == '0) begin
                n_sliced_out = 1'b1;
                push2        = (rr_cnt1 < CNT_W'(MAXT));
                n_busy       = 1'b0;
                n_from_prio  = 1'b0;
                n_from_fifo  = 1'b0;
                n_cur        = '0;
                n_slice_left = slice_dec;
            end else begin
                n_cur        = served;
                n_slice_left = slice_dec;
            end
        end
        if (push2) begin
            n_tail   = ptr_inc(tail1);
            n_rr_cnt = rr_cnt1 + CNT_W'(1);
        end

        // Priority store occupancy.
        n_prio_cnt = r_prio_cnt;
        if (arr_ok)    n_prio_cnt = r_prio_cnt + CNT_W'(1);
        if (take_prio) n_prio_cnt = r_prio_cnt - CNT_W'(1);
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
        if (i_valid && !o_stall) begin
            r_in_func        <= i_func;
            r_in_task.id     <= i_task_id;
            r_in_task.prio   <= i_priority_req;
            r_in_task.remain <= i_burst;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (proc) begin
            r_busy_res   <= n_busy_res;
            r_running_id <= n_running_id;
            r_done_res   <= n_done_res;
            r_sliced_out <= n_sliced_out;
            r_dropped    <= n_dropped;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_slice <= pprrs_pkg::SLICE_RESET;
        end else if (i_cfg_we) begin
            r_time_slice <= i_cfg_wdata;
        end
    end

    // Scheduler control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_cnt   <= '0;
            r_head       <= '0;
            r_tail       <= '0;
            r_rr_cnt     <= '0;
            r_cur        <= '0;
            r_busy       <= 1'b0;
            r_from_prio  <= 1'b0;
            r_from_fifo  <= 1'b0;
            r_slice_left <= pprrs_pkg::SLICE_RESET;
        end else if (proc) begin
            r_prio_cnt   <= n_prio_cnt;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_rr_cnt     <= n_rr_cnt;
            r_cur        <= n_cur;
            r_busy       <= n_busy;
            r_from_prio  <= n_from_prio;
            r_from_fifo  <= n_from_fifo;
            r_slice_left <= n_slice_left;
        end
    end

    // Priority store: append on arrival, close the gap on removal.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAXT; i++) begin
            if (proc && arr_ok && (r_prio_cnt[IDX_W-1:0] == IDX_W'(i))) begin
                r_prio[i] <= r_in_task;
            end else if (proc && take_prio && (IDX_W'(i) >= best.idx) && (i < MAXT - 1)) begin
                r_prio[i] <= r_prio[(i < MAXT - 1) ? i + 1 : i];
            end
        end
    end

    // Round-robin FIFO: up to two appends in one tick, at consecutive slots.
    always_ff @(posedge i_clk) begin
        if (proc && push1) begin
            r_fifo[r_tail] <= r_cur;
        end
        if (proc && push2) begin
            r_fifo[tail1] <= served;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_busy_res   = r_busy_res;
    assign o_running_id = r_running_id;
    assign o_done_res   = r_done_res;
    assign o_sliced_out = r_sliced_out;
    assign o_dropped    = r_dropped;

    // ---------------- Assertions ----------------
    a_task_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((CNT_W+1)'(r_prio_cnt) + (CNT_W+1)'(r_rr_cnt) + (CNT_W+1)'(r_busy))
            <= (CNT_W+1)'(MAXT))
        else $error("task count exceeds storage");

    a_origin_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy == (r_from_prio || r_from_fifo)) && !(r_from_prio && r_from_fifo))
        else $error("dispatch origin flags inconsistent with busy");

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_cur == '0))
        else $error("current task not cleared while idle");

    a_result_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_dropped && (r_busy_res || r_done_res || r_sliced_out)))
        else $error("arrival and tick flags mixed in one result");

    a_proc_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid)
        else $error("processed transaction produced no result");

endmodule

`default_nettype wire
